// ----- hdl/lbs_pkg.sv -----
// Package for the skinning unit: widths, command codes, queue word type.
// No dependencies.
package lbs_pkg;
  localparam int NumJoints = 24;
  localparam int FracBits  = 16;
  localparam int WordW     = 32;
  localparam int AccW      = 48;
  localparam int Entries   = 12;
  localparam int TabDepth  = NumJoints * Entries;
  localparam int TabAw     = $clog2(TabDepth);
  localparam int QDepth    = 4;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0, CMD_WEIGHT = 2'd1, CMD_VERTEX = 2'd2, CMD_NOP = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [4:0]        joint;
    logic [3:0]        entry;
    logic signed [31:0] value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_VTX, ST_SUM, ST_OUT
  } state_t;
endpackage

// ----- hdl/lbs_front.sv -----
// Front end: filters items and queues the useful ones for the back end.
// Depends on lbs_pkg.
module lbs_front import lbs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_take,
  output item_t q_item
);
  item_t q_r [QDepth];
  logic [$clog2(QDepth)-1:0] wp_r, rp_r;
  logic [$clog2(QDepth):0] cnt_r;
  logic keep, wr;

  always_comb begin
    keep = 1'b0;
    case (in_item.cmd)
      CMD_LOAD:   keep = (32'(in_item.joint) < NumJoints) && (in_item.entry < 4'(Entries));
      CMD_WEIGHT: keep = (32'(in_item.joint) < NumJoints) && (in_item.value != '0);
      CMD_VERTEX: keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign full    = (cnt_r == ($clog2(QDepth)+1)'(QDepth));
  assign wr      = push && !full && keep;
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= in_item;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (q_take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + ($clog2(QDepth)+1)'(wr) - ($clog2(QDepth)+1)'(q_take);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_take |-> q_valid)
    else $error("take from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr)
    else $error("write into full queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ($clog2(QDepth)+1)'(QDepth)) else $error("queue count overflow");
endmodule

// ----- hdl/lbs_back.sv -----
// Back end: transform table, 12-word blend accumulator, vertex transform.
// One shared 33x32 multiplier; depends on lbs_pkg.
module lbs_back import lbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_take,
  input  item_t q_item,
  output logic empty,
  input  logic pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  logic signed [WordW-1:0] tab [TabDepth];
  logic signed [WordW-1:0] rd_r;
  logic signed [AccW-1:0]  acc_r [Entries];
  logic signed [95:0]      sum_r;
  logic signed [79:0]      prod_r;
  logic signed [31:0]      res_r [3];
  state_t state_r, state_nxt;
  item_t  it_r;
  logic [3:0] idx_r, idx_nxt;
  logic       pv_r, rv_r, full_r;
  logic       hf_r, phf_r;
  logic [TabAw-1:0] raddr;
  logic       rd_en, start;

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'sh7fffffff;
    if (v < -96'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign empty  = !full_r;
  assign out_x  = res_r[0];
  assign out_y  = res_r[1];
  assign out_z  = res_r[2];

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    q_take    = 1'b0;
    start     = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.cmd)
            CMD_LOAD: q_take = 1'b1;
            CMD_WEIGHT: begin
              q_take = 1'b1; start = 1'b1;
              idx_nxt = 4'd0; state_nxt = ST_MAC;
            end
            CMD_VERTEX: begin
              if (!full_r) begin
                q_take = 1'b1; start = 1'b1; idx_nxt = 4'd0; state_nxt = ST_VTX;
              end
            end
            default: q_take = 1'b1;
          endcase
        end
      end
      ST_MAC: begin
        if (idx_r != 4'(Entries)) begin
          rd_en = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else if (!pv_r) state_nxt = ST_IDLE;
      end
      ST_VTX: begin
        if (idx_r != 4'(Entries)) begin
          if (hf_r) idx_nxt = idx_r + 1'b1;
        end else if (!pv_r) state_nxt = ST_OUT;
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign raddr = start ? TabAw'(32'(q_item.joint) * Entries)
                       : TabAw'(32'(it_r.joint) * Entries + 32'(idx_r));

  // multiplier operands; in vertex mode accumulator words go in as low and high halves
  logic signed [32:0] ma;
  logic signed [31:0] mb;
  logic signed [64:0] mp;
  logic [3:0] pidx_r;
  always_comb begin
    if (state_r == ST_MAC) begin
      ma = 33'(it_r.value); mb = rd_r;
    end else begin
      if (hf_r) ma = 33'($signed(acc_r[idx_r][AccW-1:32]));
      else ma = {1'b0, acc_r[idx_r][31:0]};
      case (idx_r[1:0])
        2'd0: mb = it_r.pos_x;
        2'd1: mb = it_r.pos_y;
        2'd2: mb = it_r.pos_z;
        default: mb = 32'sd1 <<< FracBits;
      endcase
    end
  end

  assign mp = ma * mb;

  logic signed [80:0] rp;
  logic signed [49:0] asum;
  logic signed [95:0] rs;
  logic signed [79:0] rnd;
  always_comb begin
    rp   = 81'(prod_r) + 81'(81'sd1 <<< (FracBits-1));
    rnd  = 80'(rp >>> FracBits);
    asum = 50'(rnd[49:0]) + 50'(acc_r[pidx_r]);
    if ($signed(rnd) > 80'sd140737488355327 || $signed(rnd) < -80'sd140737488355328)
      asum = rnd[79] ? 50'(-50'sd140737488355328) : 50'sd140737488355327;
    else if (asum > 50'sd140737488355327) asum = 50'sd140737488355327;
    else if (asum < -50'sd140737488355328) asum = -50'sd140737488355328;
    rs = (sum_r + (96'sd1 <<< (FracBits-1))) >>> FracBits;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid && q_item.cmd == CMD_LOAD)
      tab[TabAw'(32'(q_item.joint) * Entries + 32'(q_item.entry))] <= q_item.value;
    if (rd_en) rd_r <= tab[raddr];
    if (start) it_r <= q_item;
    prod_r <= (state_r == ST_VTX && hf_r) ? (80'(mp) <<< 32) : 80'(mp);
    pidx_r <= (state_r == ST_MAC) ? idx_r - 1'b1 : idx_r;
    phf_r  <= hf_r;
    if (state_r == ST_VTX && pv_r) begin
      if (pidx_r[1:0] == 2'd0 && !phf_r) sum_r <= 96'(prod_r);
      else sum_r <= sum_r + 96'(prod_r);
    end
    if (state_r == ST_VTX && pv_r && pidx_r[1:0] == 2'd0 && !phf_r && pidx_r != 4'd0)
      res_r[2'(pidx_r >> 2) - 2'd1] <= sat32(rs);
    if (state_r == ST_OUT) res_r[2] <= sat32(rs);
    if (!rst_n) begin
      state_r <= ST_IDLE; idx_r <= '0; pv_r <= 1'b0; rv_r <= 1'b0; full_r <= 1'b0;
      hf_r <= 1'b0;
      for (int i = 0; i < Entries; i++) acc_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      hf_r    <= (state_r == ST_VTX && idx_r != 4'(Entries)) && !hf_r;
      rv_r    <= (state_r == ST_MAC && rd_en);
      pv_r    <= (state_r == ST_MAC && rv_r) ||
                 (state_r == ST_VTX && idx_r != 4'(Entries));
      if (state_r == ST_MAC && pv_r) acc_r[pidx_r] <= AccW'(asum);
      if (state_r == ST_OUT) begin
        full_r <= 1'b1;
        for (int i = 0; i < Entries; i++) acc_r[i] <= '0;
      end else if (pop && full_r) full_r <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> full_r) else $error("result lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_take && q_item.cmd == CMD_VERTEX) |-> !full_r) else $error("vertex over result");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> (acc_r[0] == '0)) else $error("acc not cleared");
endmodule

// ----- hdl/linear_blend_skinning_top.sv -----
// Linear blend skinning unit, Q16.16. Filter queue feeds a sequential back end.
// Load: writes one table word. Weight: 12 MACs through a 2-stage read/multiply pipe.
// Vertex: 24 half-width MACs, then empty goes low; one result of three words (x, y, z).
// Ignored words never reach the back end; input stalls once 4 words are queued.
// Reset (rst_n low, synchronous) clears queue, accumulator and result flag;
// the transform table is not cleared.
module linear_blend_skinning_top import lbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_joint,
  input  logic [3:0] in_entry,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic empty,
  input  logic pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  item_t in_item, q_item;
  logic q_valid, q_take;

  always_comb begin
    in_item.cmd   = cmd_t'(in_cmd);
    in_item.joint = in_joint;
    in_item.entry = in_entry;
    in_item.value = in_value;
    in_item.pos_x = in_pos_x;
    in_item.pos_y = in_pos_y;
    in_item.pos_z = in_pos_z;
  end

  lbs_front u_front (.clk, .rst_n, .push, .full, .in_item,
                     .q_valid, .q_take, .q_item);
  lbs_back u_back (.clk, .rst_n, .q_valid, .q_take, .q_item,
                   .empty, .pop, .out_x, .out_y, .out_z);
endmodule
